// ===== src/pqs_pkg.sv =====
// Shared types, widths and constants of the polyline quad-strip extruder.
// Used by polyline_to_quad_strip and by its port checker.
package pqs_pkg;

  localparam int CoordWidth   = 16;
  localparam int CordicSteps  = 16;

  // Working widths of the datapath
  localparam int VecWidth     = CoordWidth + 4;   // vectoring x/y, covers CORDIC gain
  localparam int RotWidth     = 28;               // rotated width vector, Q.20
  localparam int ExtWidth     = RotWidth + 2;     // after sign flip and negation
  localparam int OffWidth     = ExtWidth - 16;    // offset rounded to Q.4
  localparam int SumWidth     = ((CoordWidth > OffWidth) ? CoordWidth : OffWidth) + 1;

  localparam int LwWidth      = 8;
  localparam int ZoomWidth    = 12;
  localparam int ClampWidth   = 10;
  localparam int DivAWidth    = ClampWidth + 11;  // m*2048 + 15
  localparam int MpWidth      = 17;
  localparam int WidWidth     = LwWidth + MpWidth;

  // Zoom scaling: mp = floor((m*2048 + 15) / 30) + 0.4 in Q.16
  localparam int ZoomOffset   = 140;
  localparam int ZoomLow      = 140;
  localparam int ZoomHigh     = 960;
  localparam int RecipShift   = 21;
  localparam int RecipMul     = 69905;            // floor(2^21 / 30)
  localparam int DivBy        = 30;
  localparam int MpBiasQ16    = 26214;
  localparam int MpUnity      = 65536;

  localparam longint KinvQ30  = 64'd652032874;    // inverse CORDIC gain, Q.30
  localparam int KinvWidth    = 30;

  // Configuration port
  localparam int ApbAddrWidth = 4;
  localparam int ApbDataWidth = 32;
  localparam logic [1:0] RegLineWidth = 2'd0;
  localparam logic [1:0] RegMapMode   = 2'd1;
  localparam logic [1:0] RegMapZoom   = 2'd2;
  localparam logic [LwWidth-1:0] LineWidthReset = 8'd40;

  localparam logic [1:0] LastCorner = 2'd3;

  typedef struct packed {
    logic signed [CoordWidth-1:0] point_x;
    logic signed [CoordWidth-1:0] point_y;
    logic                         path_start;
  } in_beat_t;

  typedef struct packed {
    logic signed [CoordWidth-1:0] vertex_x;
    logic signed [CoordWidth-1:0] vertex_y;
    logic [1:0]                   corner;
    logic                         last_corner;
  } out_beat_t;

  // Round a Q.20 value to Q.4, half up
  function automatic logic signed [OffWidth-1:0] to_q4(input logic signed [ExtWidth-1:0] v);
    logic signed [ExtWidth-1:0] r;
    begin
      r = v + ExtWidth'(32768);
      return r[ExtWidth-1:16];
    end
  endfunction

endpackage

// ===== src/polyline_to_quad_strip.sv =====
// Top level: polyline to quad-strip extruder with a shared CORDIC stage.
// Depends on pqs_pkg for payload types, widths and constants.
//
//   channel | dir | handshake          | content
//   in      | in  | in_valid/in_ready  | point_x, point_y, path_start
//   out     | out | out_valid/out_ready| vertex_x, vertex_y, corner, last_corner
//   apb     | in  | psel/penable       | line_width, map_mode, map_zoom
//
// A point that starts a path is stored in the accept cycle and emits nothing.
// Any other point runs through StRecip, StCorr, StWid and StKinv, then StIter, where
// the single CORDIC stage runs once per step (skipped for a zero-length segment), and
// StOffs; StEmit then gives one corner per cycle while the output is not stalled.
// The next point is taken in the cycle after the fourth corner is loaded. A stalled
// output holds the current corner and the sequencer waits with it.
// Reset clears the control state and loads the register defaults.
module polyline_to_quad_strip #(
  parameter int CORDIC_STEPS = pqs_pkg::CordicSteps
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  pqs_pkg::in_beat_t                   in_data_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output pqs_pkg::out_beat_t                  out_data_o,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [pqs_pkg::ApbAddrWidth-1:0]    paddr,
  input  logic [pqs_pkg::ApbDataWidth-1:0]    pwdata,
  output logic [pqs_pkg::ApbDataWidth-1:0]    prdata,
  output logic                                pready
);
  import pqs_pkg::*;

  localparam int IterWidth  = $clog2(CORDIC_STEPS);
  localparam int KprodWidth = WidWidth + KinvWidth;
  localparam int RecipWidth = DivAWidth + MpWidth;

  localparam logic [2:0] StIdle  = 3'd0;
  localparam logic [2:0] StRecip = 3'd1;
  localparam logic [2:0] StCorr  = 3'd2;
  localparam logic [2:0] StWid   = 3'd3;
  localparam logic [2:0] StKinv  = 3'd4;
  localparam logic [2:0] StIter  = 3'd5;
  localparam logic [2:0] StOffs  = 3'd6;
  localparam logic [2:0] StEmit  = 3'd7;

  localparam logic signed [SumWidth-1:0] CoordMax = SumWidth'((1 << (CoordWidth - 1)) - 1);
  localparam logic signed [SumWidth-1:0] CoordMin = -CoordMax - SumWidth'(1);

  // configuration registers
  logic [LwWidth-1:0]   line_width_q;
  logic                 map_mode_q;
  logic [ZoomWidth-1:0] map_zoom_q;
  logic                 cfg_wr;

  // control
  logic [2:0]           state_q, state_d;
  logic                 have_prev_q, have_prev_d;
  logic [IterWidth-1:0] iter_q, iter_d;
  logic [1:0]           k_q, k_d;
  logic                 out_valid_q, out_valid_d;

  // payload
  logic signed [CoordWidth-1:0] prev_x_q, prev_x_d, prev_y_q, prev_y_d;
  logic signed [CoordWidth-1:0] cur_x_q, cur_x_d, cur_y_q, cur_y_d;
  logic                         flip_q, flip_d, zero_q, zero_d;
  logic [DivAWidth-1:0]         a_q, a_d;
  logic [MpWidth-1:0]           q_q, q_d, mp_q, mp_d;
  logic [WidWidth-1:0]          w_q, w_d;
  logic signed [VecWidth-1:0]   x_q, x_d, y_q, y_d;
  logic signed [RotWidth-1:0]   rx_q, rx_d, ry_q, ry_d;
  logic signed [OffWidth-1:0]   o0x_q, o0x_d, o0y_q, o0y_d, o1x_q, o1x_d, o1y_q, o1y_d;
  out_beat_t                    out_q, out_d;

  // combinational helpers
  logic                         in_fire, out_load;
  logic signed [CoordWidth:0]   dx, dy;
  logic [ClampWidth-1:0]        m_clamp;
  logic [RecipWidth-1:0]        recip;
  logic [DivAWidth-1:0]         rem;
  logic [KprodWidth-1:0]        kprod;
  logic signed [VecWidth-1:0]   tx, ty;
  logic signed [RotWidth-1:0]   ux, uy;
  logic signed [ExtWidth-1:0]   c_ext, s_ext;
  logic signed [CoordWidth-1:0] base_x, base_y;
  logic signed [OffWidth-1:0]   off_x, off_y;

  function automatic logic signed [CoordWidth-1:0] sat_add(
    input logic signed [CoordWidth-1:0] p,
    input logic signed [OffWidth-1:0]   o
  );
    logic signed [SumWidth-1:0] s;
    begin
      s = SumWidth'(p) + SumWidth'(o);
      if (s > CoordMax) begin
        return CoordMax[CoordWidth-1:0];
      end else if (s < CoordMin) begin
        return CoordMin[CoordWidth-1:0];
      end
      return s[CoordWidth-1:0];
    end
  endfunction

  // ---------------- configuration port ----------------
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_width_q <= LineWidthReset;
      map_mode_q   <= 1'b0;
      map_zoom_q   <= '0;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        RegLineWidth: line_width_q <= pwdata[LwWidth-1:0];
        RegMapMode:   map_mode_q   <= pwdata[0];
        RegMapZoom:   map_zoom_q   <= pwdata[ZoomWidth-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      RegLineWidth: prdata = ApbDataWidth'(line_width_q);
      RegMapMode:   prdata = ApbDataWidth'(map_mode_q);
      RegMapZoom:   prdata = ApbDataWidth'(map_zoom_q);
      default:      prdata = '0;
    endcase
  end

  // ---------------- datapath helpers ----------------
  assign in_ready_o = (state_q == StIdle);
  assign in_fire    = in_valid_i & in_ready_o;
  assign out_load   = (state_q == StEmit) & (~out_valid_q | out_ready_i);

  assign dx = (CoordWidth+1)'(in_data_i.point_x) - (CoordWidth+1)'(prev_x_q);
  assign dy = (CoordWidth+1)'(in_data_i.point_y) - (CoordWidth+1)'(prev_y_q);

  always_comb begin
    if (map_zoom_q < ZoomWidth'(ZoomOffset + ZoomLow)) begin
      m_clamp = ClampWidth'(ZoomLow);
    end else if (map_zoom_q > ZoomWidth'(ZoomOffset + ZoomHigh)) begin
      m_clamp = ClampWidth'(ZoomHigh);
    end else begin
      m_clamp = ClampWidth'(map_zoom_q - ZoomWidth'(ZoomOffset));
    end
  end

  assign recip = RecipWidth'(a_q) * RecipWidth'(RecipMul);
  assign rem   = a_q - DivAWidth'(q_q) * DivAWidth'(DivBy);
  assign kprod = KprodWidth'(w_q) * KprodWidth'(KinvQ30)
               + (KprodWidth'(1) << (KinvWidth - 1));

  // shared CORDIC stage
  assign tx = x_q >>> iter_q;
  assign ty = y_q >>> iter_q;
  assign ux = rx_q >>> iter_q;
  assign uy = ry_q >>> iter_q;

  assign c_ext = flip_q ? -ExtWidth'(rx_q) : ExtWidth'(rx_q);
  assign s_ext = flip_q ? -ExtWidth'(ry_q) : ExtWidth'(ry_q);

  assign base_x = k_q[0] ? cur_x_q : prev_x_q;
  assign base_y = k_q[0] ? cur_y_q : prev_y_q;
  assign off_x  = k_q[1] ? o1x_q : o0x_q;
  assign off_y  = k_q[1] ? o1y_q : o0y_q;

  // ---------------- sequencer ----------------
  always_comb begin
    state_d     = state_q;
    have_prev_d = have_prev_q;
    iter_d      = iter_q;
    k_d         = k_q;
    prev_x_d    = prev_x_q;
    prev_y_d    = prev_y_q;
    cur_x_d     = cur_x_q;
    cur_y_d     = cur_y_q;
    flip_d      = flip_q;
    zero_d      = zero_q;
    a_d         = a_q;
    q_d         = q_q;
    mp_d        = mp_q;
    w_d         = w_q;
    x_d         = x_q;
    y_d         = y_q;
    rx_d        = rx_q;
    ry_d        = ry_q;
    o0x_d       = o0x_q;
    o0y_d       = o0y_q;
    o1x_d       = o1x_q;
    o1y_d       = o1y_q;
    out_d       = out_q;
    out_valid_d = out_valid_q & ~out_ready_i;

    unique case (state_q)
      StIdle: begin
        if (in_fire) begin
          if (in_data_i.path_start || !have_prev_q) begin
            // start of a path: store and emit nothing
            prev_x_d    = in_data_i.point_x;
            prev_y_d    = in_data_i.point_y;
            have_prev_d = 1'b1;
          end else begin
            cur_x_d = in_data_i.point_x;
            cur_y_d = in_data_i.point_y;
            flip_d  = dx[CoordWidth];
            zero_d  = (dx == '0) && (dy == '0);
            x_d     = dx[CoordWidth] ? -VecWidth'(dx) : VecWidth'(dx);
            y_d     = dx[CoordWidth] ? -VecWidth'(dy) : VecWidth'(dy);
            a_d     = {m_clamp, 11'd15};
            state_d = StRecip;
          end
        end
      end
      StRecip: begin
        q_d     = MpWidth'(recip >> RecipShift);
        state_d = StCorr;
      end
      StCorr: begin
        // reciprocal estimate is at most one short
        if (!map_mode_q) begin
          mp_d = MpWidth'(MpUnity);
        end else if (rem >= DivAWidth'(DivBy)) begin
          mp_d = q_q + MpWidth'(MpBiasQ16 + 1);
        end else begin
          mp_d = q_q + MpWidth'(MpBiasQ16);
        end
        state_d = StWid;
      end
      StWid: begin
        w_d     = WidWidth'(line_width_q) * WidWidth'(mp_q);
        state_d = StKinv;
      end
      StKinv: begin
        iter_d = '0;
        ry_d   = '0;
        if (zero_q) begin
          rx_d    = RotWidth'(w_q);
          state_d = StOffs;
        end else begin
          rx_d    = RotWidth'(kprod[KprodWidth-1:KinvWidth]);
          state_d = StIter;
        end
      end
      StIter: begin
        if (!y_q[VecWidth-1]) begin
          x_d  = x_q + ty;
          y_d  = y_q - tx;
          rx_d = rx_q - uy;
          ry_d = ry_q + ux;
        end else begin
          x_d  = x_q - ty;
          y_d  = y_q + tx;
          rx_d = rx_q + uy;
          ry_d = ry_q - ux;
        end
        iter_d = iter_q + IterWidth'(1);
        if (iter_q == IterWidth'(CORDIC_STEPS - 1)) begin
          state_d = StOffs;
        end
      end
      StOffs: begin
        o0x_d   = to_q4(s_ext);
        o0y_d   = to_q4(-c_ext);
        o1x_d   = to_q4(-s_ext);
        o1y_d   = to_q4(c_ext);
        k_d     = 2'd0;
        state_d = StEmit;
      end
      StEmit: begin
        if (out_load) begin
          out_d.vertex_x    = sat_add(base_x, off_x);
          out_d.vertex_y    = sat_add(base_y, off_y);
          out_d.corner      = k_q;
          out_d.last_corner = (k_q == LastCorner);
          out_valid_d       = 1'b1;
          k_d               = k_q + 2'd1;
          if (k_q == LastCorner) begin
            // advance: current point becomes the segment start
            prev_x_d = cur_x_q;
            prev_y_d = cur_y_q;
            state_d  = StIdle;
          end
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      have_prev_q <= 1'b0;
      iter_q      <= '0;
      k_q         <= '0;
      out_valid_q <= 1'b0;
      prev_x_q    <= '0;
      prev_y_q    <= '0;
    end else begin
      state_q     <= state_d;
      have_prev_q <= have_prev_d;
      iter_q      <= iter_d;
      k_q         <= k_d;
      out_valid_q <= out_valid_d;
      prev_x_q    <= prev_x_d;
      prev_y_q    <= prev_y_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_x_q <= cur_x_d;
    cur_y_q <= cur_y_d;
    flip_q  <= flip_d;
    zero_q  <= zero_d;
    a_q     <= a_d;
    q_q     <= q_d;
    mp_q    <= mp_d;
    w_q     <= w_d;
    x_q     <= x_d;
    y_q     <= y_d;
    rx_q    <= rx_d;
    ry_q    <= ry_d;
    o0x_q   <= o0x_d;
    o0y_q   <= o0y_d;
    o1x_q   <= o1x_d;
    o1y_q   <= o1y_d;
    out_q   <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ===== src/pqs_checker.sv =====
// Port-level checker for polyline_to_quad_strip, attached with bind.
// Depends on pqs_pkg for the payload types.
module pqs_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_ready_o,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input pqs_pkg::out_beat_t out_data_o
);
  import pqs_pkg::*;

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("output beat changed while stalled");

  a_last_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.last_corner == (out_data_o.corner == LastCorner)))
    else $error("last_corner does not match corner");

  // corners of a quad follow back to back
  a_corner_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && !out_data_o.last_corner |=>
      out_valid_o && (out_data_o.corner == 2'($past(out_data_o.corner) + 2'd1)))
    else $error("quad corner sequence broken");

  a_quad_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> (out_data_o.corner == 2'd0))
    else $error("quad does not start at corner 0");

  a_busy_in_quad: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.last_corner |-> !in_ready_o)
    else $error("input taken while a quad is still being emitted");

endmodule

bind polyline_to_quad_strip pqs_checker u_pqs_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);

// ===== verif/polyline_to_quad_strip_test.sv =====
`timescale 1ns / 1ps
// Self-checking testbench of polyline_to_quad_strip: random and directed polyline points
// in, quad corners out, compared with a behavioral extruder. Needs pqs_pkg and the block.
module polyline_to_quad_strip_test;
  import pqs_pkg::*;

  localparam logic [1:0] RegSpare = 2'd3;
  localparam int SettleCycles = 40;
  localparam int PrintLimit   = 100;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  in_beat_t    in_data_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  out_beat_t   out_data_o;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [ApbAddrWidth-1:0] paddr = '0;
  logic [ApbDataWidth-1:0] pwdata = '0;
  logic [ApbDataWidth-1:0] prdata;
  logic        pready;

  in_beat_t    pending_points[$];
  out_beat_t   expected_corners[$];
  int          points_queued = 0;
  int          points_taken = 0;
  int          fail_count = 0;
  int          idle_pct = 34;

  // Shadow registers and extruder state
  logic [LwWidth-1:0]   cfg_line_width = LineWidthReset;
  logic                 cfg_map_mode = 1'b0;
  logic [ZoomWidth-1:0] cfg_map_zoom = '0;
  longint               prev_x = 0;
  longint               prev_y = 0;
  bit                   have_prev = 1'b0;

  polyline_to_quad_strip u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  always #5 clk_i = ~clk_i;

  task automatic report_mismatch(input string msg);
    if (fail_count < PrintLimit) $display("mismatch @%0t: %s", $realtime, msg);
    fail_count++;
  endtask

  function automatic longint clamp_coord(input longint v);
    longint hi;
    hi = (longint'(1) <<< (CoordWidth - 1)) - 1;
    if (v > hi) return hi;
    if (v < -hi - 1) return -hi - 1;
    return v;
  endfunction

  // Q.20 to Q.4, round half up
  function automatic longint round_q4(input longint v);
    return (v + 32768) >>> 16;
  endfunction

  task automatic extrude_point(input in_beat_t pt);
    longint cx, cy, mp, m, wid, dx, dy, c, s;
    longint x, y, rx, ry, tx, ty, ux, uy;
    longint o0x, o0y, o1x, o1y, bx, by;
    bit flip;
    out_beat_t v;
    cx = longint'($signed(pt.point_x));
    cy = longint'($signed(pt.point_y));
    if (pt.path_start || !have_prev) begin
      prev_x = cx;
      prev_y = cy;
      have_prev = 1'b1;
      return;
    end
    mp = MpUnity;
    if (cfg_map_mode) begin
      m = longint'(cfg_map_zoom) - ZoomOffset;
      if (m < ZoomLow) m = ZoomLow;
      else if (m > ZoomHigh) m = ZoomHigh;
      mp = (m * 65536 + 480) / 960 + MpBiasQ16;
    end
    wid = longint'(cfg_line_width) * mp;
    dx = cx - prev_x;
    dy = cy - prev_y;
    if (dx == 0 && dy == 0) begin
      c = wid;
      s = 0;
    end else begin
      flip = dx < 0;
      x = flip ? -dx : dx;
      y = flip ? -dy : dy;
      rx = (wid * KinvQ30 + (longint'(1) <<< 29)) >>> 30;
      ry = 0;
      // vector the delta onto x; steer the width vector with the same signs
      for (int i = 0; i < CordicSteps; i++) begin
        tx = x >>> i;
        ty = y >>> i;
        ux = rx >>> i;
        uy = ry >>> i;
        if (y >= 0) begin
          x += ty; y -= tx;
          rx -= uy; ry += ux;
        end else begin
          x -= ty; y += tx;
          rx += uy; ry -= ux;
        end
      end
      c = flip ? -rx : rx;
      s = flip ? -ry : ry;
    end
    o0x = round_q4(s);
    o0y = round_q4(-c);
    o1x = round_q4(-s);
    o1y = round_q4(c);
    for (int k = 0; k < 4; k++) begin
      bx = (k % 2) ? cx : prev_x;
      by = (k % 2) ? cy : prev_y;
      v.vertex_x = CoordWidth'(clamp_coord(bx + ((k >= 2) ? o1x : o0x)));
      v.vertex_y = CoordWidth'(clamp_coord(by + ((k >= 2) ? o1y : o0y)));
      v.corner = 2'(k);
      v.last_corner = (2'(k) == LastCorner);
      expected_corners.push_back(v);
    end
    prev_x = cx;
    prev_y = cy;
  endtask

  task automatic check_corner(input out_beat_t got);
    out_beat_t want;
    if (expected_corners.size() == 0) begin
      report_mismatch($sformatf("unexpected corner x=%0d y=%0d c=%0d",
                                got.vertex_x, got.vertex_y, got.corner));
      return;
    end
    want = expected_corners.pop_front();
    if (got.vertex_x !== want.vertex_x || got.vertex_y !== want.vertex_y ||
        got.corner !== want.corner || got.last_corner !== want.last_corner)
      report_mismatch($sformatf("got x=%0d y=%0d c=%0d l=%0b, want x=%0d y=%0d c=%0d l=%0b",
                                got.vertex_x, got.vertex_y, got.corner, got.last_corner,
                                want.vertex_x, want.vertex_y, want.corner, want.last_corner));
  endtask

  // Point driver: predict on acceptance, then load the next beat or drop valid
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        extrude_point(in_data_i);
        points_taken++;
      end
      if (!in_valid_i || in_ready_o) begin
        if (pending_points.size() != 0 && $urandom_range(99) >= idle_pct) begin
          in_data_i <= pending_points.pop_front();
          in_valid_i <= 1'b1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Corner monitor with random back-pressure
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) check_corner(out_data_o);
      out_ready_i <= ($urandom_range(99) >= idle_pct);
    end
  end

  function automatic logic [ApbDataWidth-1:0] reg_value(input logic [1:0] idx);
    case (idx)
      RegLineWidth: return ApbDataWidth'(cfg_line_width);
      RegMapMode:   return ApbDataWidth'(cfg_map_mode);
      RegMapZoom:   return ApbDataWidth'(cfg_map_zoom);
      default:      return '0;
    endcase
  endfunction

  task automatic apb_write(input logic [1:0] idx, input logic [ApbDataWidth-1:0] val);
    @(posedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      RegLineWidth: cfg_line_width = val[LwWidth-1:0];
      RegMapMode:   cfg_map_mode = val[0];
      RegMapZoom:   cfg_map_zoom = val[ZoomWidth-1:0];
      default:      ;
    endcase
  endtask

  task automatic apb_read_check(input logic [1:0] idx);
    @(posedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= {idx, 2'b00};
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata !== reg_value(idx))
      report_mismatch($sformatf("register %0d reads %0h, want %0h",
                                idx, prdata, reg_value(idx)));
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  // Write all registers with junk in the unused upper bits, then read them back
  task automatic configure(input logic [LwWidth-1:0] lw, input logic mode,
                           input logic [ZoomWidth-1:0] zoom);
    logic [ApbDataWidth-1:0] pw;
    pw = $urandom;
    pw[LwWidth-1:0] = lw;
    apb_write(RegLineWidth, pw);
    pw = $urandom;
    pw[0] = mode;
    apb_write(RegMapMode, pw);
    pw = $urandom;
    pw[ZoomWidth-1:0] = zoom;
    apb_write(RegMapZoom, pw);
    apb_read_check(RegLineWidth);
    apb_read_check(RegMapMode);
    apb_read_check(RegMapZoom);
  endtask

  task automatic queue_point(input logic signed [CoordWidth-1:0] px,
                             input logic signed [CoordWidth-1:0] py, input logic start);
    in_beat_t pt;
    pt.point_x = px;
    pt.point_y = py;
    pt.path_start = start;
    pending_points.push_back(pt);
    points_queued++;
  endtask

  // Mostly well-formed polylines walking by random steps, some lone noise points
  task automatic queue_random_paths(input int segments);
    int made, run, span, dx, dy;
    logic signed [CoordWidth-1:0] wx, wy;
    made = 0;
    while (made < segments) begin
      if ($urandom_range(9) == 0) begin
        queue_point(CoordWidth'($urandom), CoordWidth'($urandom), 1'($urandom_range(1)));
        made++;
      end else begin
        wx = CoordWidth'($urandom);
        wy = CoordWidth'($urandom);
        queue_point(wx, wy, 1'b1);
        run = $urandom_range(8, 1);
        span = 1 << $urandom_range(15);
        repeat (run) begin
          // hold the point now and then for a zero-length segment
          if ($urandom_range(7) != 0) begin
            dx = int'($urandom_range(2 * span)) - span;
            dy = int'($urandom_range(2 * span)) - span;
            wx = CoordWidth'(wx + dx);
            wy = CoordWidth'(wy + dy);
          end
          queue_point(wx, wy, 1'b0);
          made++;
        end
      end
    end
  endtask

  // Wait until every point is taken and every corner seen, then let the block settle
  task automatic drain();
    while (points_taken != points_queued || expected_corners.size() != 0)
      @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    apb_read_check(RegLineWidth);
    apb_read_check(RegMapMode);
    apb_read_check(RegMapZoom);

    // point with no predecessor acts as a path start
    queue_point(16'sd100, 16'sd200, 1'b0);
    queue_point(16'sd100, 16'sd200, 1'b0);
    queue_point(16'sd260, 16'sd200, 1'b0);
    queue_point(16'sd260, 16'sd40, 1'b0);
    queue_point(-16'sd300, 16'sd40, 1'b0);
    queue_point(-16'sd300, 16'sd500, 1'b0);
    queue_point(-16'sd500, 16'sd300, 1'b0);
    queue_point(-16'sd32768, -16'sd32768, 1'b1);
    queue_point(16'sd32767, 16'sd32767, 1'b0);
    queue_point(16'sd32767, -16'sd32768, 1'b0);
    queue_point(-16'sd32768, 16'sd32767, 1'b0);
    queue_point(-16'sd32768, -16'sd32768, 1'b0);
    queue_point(16'sd32767, 16'sd32767, 1'b1);
    queue_point(16'sd32767, 16'sd32767, 1'b0);
    queue_point(-16'sd32768, -16'sd32768, 1'b1);
    queue_point(-16'sd32768, -16'sd32768, 1'b0);
    queue_point(16'sd1, 16'sd0, 1'b1);
    queue_point(16'sd0, 16'sd0, 1'b0);
    queue_point(16'sd0, 16'sd1, 1'b0);
    queue_point(16'sd1, -16'sd1, 1'b0);
    queue_point(-16'sd1, -16'sd2, 1'b0);
    queue_random_paths(37);
    drain();

    // widest line, no idling on either side
    idle_pct = 0;
    configure(8'd255, 1'b1, 12'd4095);
    queue_point(16'sd32767, 16'sd32767, 1'b1);
    queue_point(16'sd32767, 16'sd32767, 1'b0);
    queue_point(16'sd32767, -16'sd32768, 1'b0);
    queue_random_paths(43);
    drain();

    idle_pct = 34;
    configure(8'd0, 1'b1, 12'd0);
    queue_random_paths(37);
    drain();

    apb_write(RegSpare, $urandom);
    configure(8'd1, 1'b1, 12'd280);
    queue_random_paths(37);
    drain();

    configure(8'($urandom), 1'b1, 12'd1100);
    queue_random_paths(37);
    drain();

    configure(8'd255, 1'b0, 12'($urandom));
    queue_point(-16'sd32768, -16'sd32768, 1'b1);
    queue_point(-16'sd32768, -16'sd32768, 1'b0);
    queue_random_paths(37);
    drain();

    configure(8'($urandom), 1'b1, 12'($urandom));
    queue_random_paths(37);
    drain();

    if (fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("FAIL");
    $finish;
  end

endmodule
